// ===== rtl/hsv_pkg.sv =====
`timescale 1ns / 1ps

package hsv_pkg;

  localparam int ChannelBits = 8;
  localparam int HueBits     = 13;
  localparam int HueTurn     = 5760;
  localparam int HueSector   = 960;

  // The hue numerator is 960 times a sector term below 6 * 2^ChannelBits.
  localparam int HueNumBits  = HueBits + ChannelBits;
  localparam int SatNumBits  = 2 * ChannelBits;
  localparam int SecTermBits = ChannelBits + 3;

  localparam int PipeDepth   = (HueBits > ChannelBits) ? HueBits : ChannelBits;
  localparam int FifoDepth   = 2;

  typedef struct packed {
    logic [ChannelBits-1:0] red_in;
    logic [ChannelBits-1:0] green_in;
    logic [ChannelBits-1:0] blue_in;
    logic [ChannelBits-1:0] alpha_in;
  } pixel_t;

  typedef struct packed {
    logic [HueBits-1:0]     hue_out;
    logic [ChannelBits-1:0] saturation_out;
    logic [ChannelBits-1:0] value_out;
    logic [ChannelBits-1:0] alpha_out;
  } hsv_t;

  typedef struct packed {
    logic [HueNumBits-1:0]  hue_num;
    logic [SatNumBits-1:0]  sat_num;
    logic [ChannelBits-1:0] delta;
    logic [ChannelBits-1:0] value;
    logic [ChannelBits-1:0] alpha;
  } work_t;

endpackage

// ===== rtl/hsv_front.sv =====
`timescale 1ns / 1ps

module hsv_front import hsv_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start,
  output logic   busy,
  input  pixel_t pixel_i,
  input  logic   full_i,
  output logic   push_o,
  output work_t  work_o
);

  logic                   valid_q;
  pixel_t                 pix_q;
  logic                   accept;
  logic [ChannelBits-1:0] r, g, b;
  logic [ChannelBits-1:0] mx, mn, dl;
  logic [SecTermBits-1:0] k;

  assign push_o = valid_q && !full_i;
  assign busy   = valid_q && full_i;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q <= pixel_i;
    end
  end

  assign r = pix_q.red_in;
  assign g = pix_q.green_in;
  assign b = pix_q.blue_in;

  always_comb begin
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dl = mx - mn;
  end

  // Sector term in units of 60 degrees times delta; a negative red-sector
  // hue is wrapped by a full turn (six sectors) here, before the division.
  always_comb begin
    if (mx == r) begin
      if (g >= b) begin
        k = SecTermBits'(g - b);
      end else begin
        k = (SecTermBits'(dl) << 2) + (SecTermBits'(dl) << 1) - SecTermBits'(b - g);
      end
    end else if (mx == g) begin
      k = (SecTermBits'(dl) << 1) + SecTermBits'(b) - SecTermBits'(r);
    end else begin
      k = (SecTermBits'(dl) << 2) + SecTermBits'(r) - SecTermBits'(g);
    end
  end

  always_comb begin
    work_o.hue_num = HueNumBits'(k) * HueNumBits'(HueSector);
    work_o.sat_num = (SatNumBits'(dl) << ChannelBits) - SatNumBits'(dl);
    work_o.delta   = dl;
    work_o.value   = mx;
    work_o.alpha   = pix_q.alpha_in;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) busy |=> $stable(pix_q))
    else $error("Held pixel changed while the front end was stalled.");

endmodule

// ===== rtl/hsv_fifo.sv =====
`timescale 1ns / 1ps

module hsv_fifo import hsv_pkg::*; #(
  parameter int DEPTH = FifoDepth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  work_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output work_t data_o,
  output logic  empty_o
);

  localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntBits = $clog2(DEPTH + 1);

  work_t              mem_q [DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] count_q;

  assign full_o  = (count_q == CntBits'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("Push into a full queue.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("Pop from an empty queue.");

endmodule

// ===== rtl/hsv_div.sv =====
`timescale 1ns / 1ps

module hsv_div #(
  parameter int NUM_W   = 21,
  parameter int DEN_W   = 8,
  parameter int QUO_W   = 13,
  parameter int LATENCY = 13
) (
  input  logic             clk_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);

  localparam int CmpW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [CmpW-1:0]  rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];

  // One restoring step per stage, most significant quotient bit first.
  // The caller guarantees num < den * 2^QUO_W.
  for (genvar s = 0; s < QUO_W; s++) begin : g_step
    localparam int Bit = QUO_W - 1 - s;
    logic [CmpW-1:0]  rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [CmpW-1:0]  den_sh;
    logic             fits;

    if (s == 0) begin : g_first
      assign rem_in = CmpW'(num_i);
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign den_sh = CmpW'(den_in) << Bit;
    assign fits   = (rem_in >= den_sh);

    always_ff @(posedge clk_i) begin
      rem_q[s] <= fits ? rem_in - den_sh : rem_in;
      den_q[s] <= den_in;
      quo_q[s] <= quo_in | (QUO_W'(fits) << Bit);
    end
  end

  if (LATENCY > QUO_W) begin : g_hold
    logic [QUO_W-1:0] hold_q [LATENCY-QUO_W];
    for (genvar h = 0; h < LATENCY - QUO_W; h++) begin : g_tap
      always_ff @(posedge clk_i) begin
        hold_q[h] <= (h == 0) ? quo_q[QUO_W-1] : hold_q[(h == 0) ? 0 : h - 1];
      end
    end
    assign quo_o = hold_q[LATENCY-QUO_W-1];
  end else begin : g_direct
    assign quo_o = quo_q[QUO_W-1];
  end

endmodule

// ===== rtl/hsv_back.sv =====
`timescale 1ns / 1ps

module hsv_back import hsv_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  work_t work_i,
  output logic  result_valid_o,
  output hsv_t  hsv_o
);

  typedef struct packed {
    logic                   grey;
    logic [ChannelBits-1:0] value;
    logic [ChannelBits-1:0] alpha;
  } side_t;

  logic                   valid_q [PipeDepth];
  side_t                  side_q  [PipeDepth];
  side_t                  side_in;
  logic [HueBits-1:0]     hue_quo;
  logic [ChannelBits-1:0] sat_quo;
  logic                   done_q;
  hsv_t                   out_q;

  hsv_div #(
    .NUM_W   (HueNumBits),
    .DEN_W   (ChannelBits),
    .QUO_W   (HueBits),
    .LATENCY (PipeDepth)
  ) u_hue_div (
    .clk_i (clk_i),
    .num_i (work_i.hue_num),
    .den_i (work_i.delta),
    .quo_o (hue_quo)
  );

  hsv_div #(
    .NUM_W   (SatNumBits),
    .DEN_W   (ChannelBits),
    .QUO_W   (ChannelBits),
    .LATENCY (PipeDepth)
  ) u_sat_div (
    .clk_i (clk_i),
    .num_i (work_i.sat_num),
    .den_i (work_i.value),
    .quo_o (sat_quo)
  );

  assign side_in.grey  = (work_i.delta == '0);
  assign side_in.value = work_i.value;
  assign side_in.alpha = work_i.alpha;

  for (genvar s = 0; s < PipeDepth; s++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= (s == 0) ? valid_i : valid_q[(s == 0) ? 0 : s - 1];
      end
    end
    always_ff @(posedge clk_i) begin
      side_q[s] <= (s == 0) ? side_in : side_q[(s == 0) ? 0 : s - 1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_q[PipeDepth-1];
    end
  end

  // A grey pixel divides by zero; its quotients are replaced here.
  always_ff @(posedge clk_i) begin
    out_q.hue_out        <= side_q[PipeDepth-1].grey ? '0 : hue_quo;
    out_q.saturation_out <= side_q[PipeDepth-1].grey ? '0 : sat_quo;
    out_q.value_out      <= side_q[PipeDepth-1].value;
    out_q.alpha_out      <= side_q[PipeDepth-1].alpha;
  end

  assign result_valid_o = done_q;
  assign hsv_o          = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> ##(PipeDepth + 1) done_q)
    else $error("Transaction did not complete after the fixed pipeline latency.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (out_q.hue_out < HueBits'(HueTurn)))
    else $error("Hue outside one full turn.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && (out_q.value_out == '0) |-> (out_q.saturation_out == '0)
                                          && (out_q.hue_out == '0))
    else $error("Black pixel produced nonzero hue or saturation.");

endmodule

// ===== rtl/rgb_to_hsv_converter.sv =====
`timescale 1ns / 1ps

// Converts one RGBA pixel per clock while busy is low to hue, saturation, value
// and alpha. A pixel is taken at each clock edge where start is high and busy is
// low, and its result appears on hsv_o for exactly one cycle with result_valid_o
// high. On its way it passes the input register, the queue, then a 13-stage
// divider that resolves one hue quotient bit per stage (saturation is divided
// alongside), then the output register. The receiver cannot stall, so the back
// end drains the queue every cycle and busy stays low in normal operation; it
// rises only if the queue were ever full.
module rgb_to_hsv_converter import hsv_pkg::*; #(
  parameter int FIFO_DEPTH = FifoDepth
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start,
  output logic   busy,
  input  pixel_t pixel_i,
  output logic   result_valid_o,
  output hsv_t   hsv_o
);

  logic  push, full, pop, empty;
  work_t front_work, back_work;

  hsv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .pixel_i (pixel_i),
    .full_i  (full),
    .push_o  (push),
    .work_o  (front_work)
  );

  hsv_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_work),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (back_work),
    .empty_o (empty)
  );

  assign pop = !empty;

  hsv_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (pop),
    .work_i         (back_work),
    .result_valid_o (result_valid_o),
    .hsv_o          (hsv_o)
  );

endmodule

// ===== dv/rgb_to_hsv_converter_tb.sv =====
`timescale 1ns / 1ps

module rgb_to_hsv_converter_tb;
  import hsv_pkg::*;

  localparam int NumRandom   = 550;
  localparam int CycleLimit  = 100000;
  localparam int DrainCycles = 24;
  localparam int ChanMax     = (1 << ChannelBits) - 1;

  typedef struct {
    pixel_t px;
    bit     typed;
    hsv_t   want;
  } dir_row_t;

  typedef struct {
    pixel_t px;
    hsv_t   hsv;
  } pending_hsv_t;

  localparam int NumDirected = 23;

  // Rows with typed == 1 carry their result; the rest go through the predictor.
  dir_row_t dir_rows [0:NumDirected-1] = '{
    '{{8'd0,   8'd0,   8'd0,   8'd0},   1'b1, {13'd0,    8'd0,   8'd0,   8'd0}},
    '{{8'd255, 8'd255, 8'd255, 8'd255}, 1'b1, {13'd0,    8'd0,   8'd255, 8'd255}},
    '{{8'd128, 8'd128, 8'd128, 8'd77},  1'b1, {13'd0,    8'd0,   8'd128, 8'd77}},
    '{{8'd255, 8'd0,   8'd0,   8'd255}, 1'b1, {13'd0,    8'd255, 8'd255, 8'd255}},
    '{{8'd0,   8'd255, 8'd0,   8'd0},   1'b1, {13'd1920, 8'd255, 8'd255, 8'd0}},
    '{{8'd0,   8'd0,   8'd255, 8'd128}, 1'b1, {13'd3840, 8'd255, 8'd255, 8'd128}},
    '{{8'd255, 8'd255, 8'd0,   8'd1},   1'b1, {13'd960,  8'd255, 8'd255, 8'd1}},
    '{{8'd0,   8'd255, 8'd255, 8'd254}, 1'b1, {13'd2880, 8'd255, 8'd255, 8'd254}},
    '{{8'd255, 8'd0,   8'd255, 8'd170}, 1'b1, {13'd4800, 8'd255, 8'd255, 8'd170}},
    '{{8'd255, 8'd0,   8'd1,   8'd85},  1'b0, '0},
    '{{8'd1,   8'd0,   8'd0,   8'd255}, 1'b0, '0},
    '{{8'd255, 8'd254, 8'd0,   8'd0},   1'b0, '0},
    '{{8'd0,   8'd1,   8'd255, 8'd15},  1'b0, '0},
    '{{8'd200, 8'd100, 8'd50,  8'd240}, 1'b0, '0},
    '{{8'd1,   8'd1,   8'd0,   8'd3},   1'b0, '0},
    '{{8'd0,   8'd1,   8'd1,   8'd252}, 1'b0, '0},
    '{{8'd1,   8'd0,   8'd1,   8'd12},  1'b0, '0},
    '{{8'd254, 8'd255, 8'd255, 8'd195}, 1'b0, '0},
    '{{8'd255, 8'd255, 8'd254, 8'd60},  1'b0, '0},
    '{{8'd85,  8'd170, 8'd255, 8'd90},  1'b0, '0},
    '{{8'd10,  8'd255, 8'd9,   8'd165}, 1'b0, '0},
    '{{8'd128, 8'd0,   8'd127, 8'd48},  1'b0, '0},
    '{{8'd2,   8'd1,   8'd3,   8'd207}, 1'b0, '0}
  };

  logic   clk_i = 1'b0;
  logic   rst_ni;
  logic   start;
  logic   busy;
  pixel_t pixel_i;
  logic   result_valid_o;
  hsv_t   hsv_o;

  pending_hsv_t hsv_expected_q[$];
  pending_hsv_t oldest_hsv;
  int           mismatch_count = 0;
  int           cycle_count = 0;

  rgb_to_hsv_converter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .pixel_i        (pixel_i),
    .result_valid_o (result_valid_o),
    .hsv_o          (hsv_o)
  );

  always #1 clk_i = ~clk_i;

  // Exact integer hue: the red sector wraps before dividing, so the
  // quotient is the floor of the wrapped hue.
  function automatic hsv_t hsv_of(pixel_t px);
    int   r, g, b, top, bottom, delta, num, hue;
    hsv_t res;
    r      = int'(px.red_in);
    g      = int'(px.green_in);
    b      = int'(px.blue_in);
    top    = (r > g) ? r : g;
    top    = (b > top) ? b : top;
    bottom = (r < g) ? r : g;
    bottom = (b < bottom) ? b : bottom;
    delta  = top - bottom;
    res    = '0;
    if (delta != 0) begin
      if (top == r) begin
        num = HueSector * (g - b);
        if (num < 0) num += HueTurn * delta;
      end else if (top == g) begin
        num = 2 * HueSector * delta + HueSector * (b - r);
      end else begin
        num = 4 * HueSector * delta + HueSector * (r - g);
      end
      hue = num / delta;
      if (hue >= HueTurn) hue -= HueTurn;
      res.hue_out        = HueBits'(hue);
      res.saturation_out = ChannelBits'((ChanMax * delta) / top);
    end
    res.value_out = ChannelBits'(top);
    res.alpha_out = px.alpha_in;
    return res;
  endfunction

  function automatic logic [ChannelBits-1:0] near_extreme();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return ChannelBits'(1);
      2:       return ChannelBits'(ChanMax - 1);
      default: return ChannelBits'(ChanMax);
    endcase
  endfunction

  // Half free pixels, the rest greys, ties, extremes, dark pixels and near-greys.
  function automatic pixel_t random_pixel();
    pixel_t px;
    logic [ChannelBits-1:0] lvl;
    px  = $urandom;
    lvl = ChannelBits'($urandom);
    case ($urandom_range(0, 9))
      5: begin
        px.red_in   = lvl;
        px.green_in = lvl;
        px.blue_in  = lvl;
      end
      6: begin
        case ($urandom_range(0, 2))
          0:       px.green_in = px.red_in;
          1:       px.blue_in  = px.green_in;
          default: px.blue_in  = px.red_in;
        endcase
      end
      7: begin
        px.red_in   = near_extreme();
        px.green_in = near_extreme();
        px.blue_in  = near_extreme();
      end
      8: begin
        px.red_in   = ChannelBits'($urandom_range(0, 3));
        px.green_in = ChannelBits'($urandom_range(0, 3));
        px.blue_in  = ChannelBits'($urandom_range(0, 3));
      end
      9: begin
        lvl         = ChannelBits'($urandom_range(1, ChanMax));
        px.red_in   = lvl - ChannelBits'($urandom_range(0, 1));
        px.green_in = lvl - ChannelBits'($urandom_range(0, 1));
        px.blue_in  = lvl - ChannelBits'($urandom_range(0, 1));
      end
      default: ;
    endcase
    return px;
  endfunction

  // Holds the pixel until the block takes it; start stays high on return.
  task automatic send_pixel(input pixel_t px, input bit typed, input hsv_t want);
    pending_hsv_t entry;
    pixel_i <= px;
    start   <= 1'b1;
    do @(posedge clk_i); while (busy);
    entry.px  = px;
    entry.hsv = typed ? want : hsv_of(px);
    hsv_expected_q.push_back(entry);
  endtask

  task automatic idle_between(inout int burst_left);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 12);
      gap        = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    int burst_left;
    burst_left = 0;
    rst_ni  <= 1'b0;
    start   <= 1'b0;
    pixel_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      send_pixel(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].want);
      idle_between(burst_left);
    end
    for (int i = 0; i < NumRandom; i++) begin
      send_pixel(random_pixel(), 1'b0, '0);
      idle_between(burst_left);
    end
    start <= 1'b0;

    while (hsv_expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0 && hsv_expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (hsv_expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected transaction: hue %0d sat %0d val %0d alpha %0d",
                   hsv_o.hue_out, hsv_o.saturation_out, hsv_o.value_out, hsv_o.alpha_out);
      end else begin
        oldest_hsv = hsv_expected_q.pop_front();
        if (hsv_o.hue_out !== oldest_hsv.hsv.hue_out ||
            hsv_o.saturation_out !== oldest_hsv.hsv.saturation_out ||
            hsv_o.value_out !== oldest_hsv.hsv.value_out ||
            hsv_o.alpha_out !== oldest_hsv.hsv.alpha_out) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch rgba %0d %0d %0d %0d: want hue %0d sat %0d val %0d alpha %0d, %s",
                     oldest_hsv.px.red_in, oldest_hsv.px.green_in, oldest_hsv.px.blue_in,
                     oldest_hsv.px.alpha_in, oldest_hsv.hsv.hue_out,
                     oldest_hsv.hsv.saturation_out, oldest_hsv.hsv.value_out,
                     oldest_hsv.hsv.alpha_out,
                     $sformatf("got hue %0d sat %0d val %0d alpha %0d", hsv_o.hue_out,
                               hsv_o.saturation_out, hsv_o.value_out, hsv_o.alpha_out));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
